// File: design/clp_pkg.sv
// Shared types and constants of the calibrated line position core.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package clp_pkg;

  // Fixed field widths
  localparam int CH_W        = 4;   // channel index
  localparam int RAW_W       = 10;  // raw sample port
  localparam int CFG_W       = 5;   // widest configuration register
  localparam int CFG_IDX_W   = 1;   // configuration register index
  localparam int VALUE_W     = 10;  // calibrated value 0..1000
  localparam int POS_W       = 14;  // line position
  localparam int WSUM_W      = 28;  // weighted sum accumulator
  localparam int WTOT_W      = 14;  // weight total accumulator
  localparam int MAX_SAMPLE_W = 12; // widest supported sample

  // Divider geometry
  localparam int DIVIDEND_W  = WSUM_W;
  localparam int DIVISOR_W   = WTOT_W;
  localparam int SHORT_Q     = VALUE_W;  // quotient bits of a normalize divide
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  // Arithmetic constants
  localparam int FULL_SCALE  = 1000;
  localparam int THRESHOLD   = 50;

  // Codes
  localparam logic OP_CALIBRATE = 1'b0;
  localparam logic OP_MEASURE   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LINE      = 1'b1;

  // Classified sample, as queued between front and back
  typedef struct packed {
    logic             is_meas;   // measurement, else calibration
    logic             ch_known;  // channel below MAX_CHANNELS
    logic             in_scan;   // channel below channels in use
    logic             last;      // channel ends the scan
    logic [CH_W-1:0]  channel;
    logic [RAW_W-1:0] raw;
  } entry_t;

  // Divider request
  typedef struct packed {
    logic start;       // load operands this cycle
    logic short_mode;  // quotient known to fit in SHORT_Q bits
  } div_req_t;

endpackage

`default_nettype wire

// File: design/calibrated_line_position_core.sv
// Top level of the calibrated line position core: configuration registers,
// front end, sample queue and back end. Depends on clp_pkg, clp_front,
// clp_queue and clp_back.
//
// Usage: sample beats (opcode, channel, raw_sample) enter on the
// sample_valid/sample_stall channel. A calibration beat widens the channel's
// stored min/max and gives no result. A measurement beat gives one result
// beat on result_valid/result_stall: the value normalized to 0..1000, and on
// the last channel of a scan also line_found and the weighted line position.
// The front end classifies each beat and drops it into a four-entry queue;
// sample_stall rises only while that queue is full.
// Timing is set by the back end, which works on one beat at a time and owns a
// serial divider giving one quotient bit per cycle. A calibration beat
// passes through S_CAL; a measurement through S_NORM, S_PROD, S_SUM, S_END
// and S_EMIT, with S_NDIV after S_NORM when a normalize divide of ten
// quotient bits is needed, and S_PDIV after S_END at a scan end with a
// nonzero weight total, for the 28-bit position divide.
// A finished result waits in the output register; while the receiver stalls,
// the back end holds the next measurement at its emit step, the queue fills
// and sample_stall rises.
// Reset (rst, synchronous) empties the queue, clears the accumulators, sets
// min to all ones and max to zero for every channel, channels_in_use to 8 and
// white_line to 0. Write configuration only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module calibrated_line_position_core #(
  parameter int MAX_CHANNELS = 16,
  parameter int SAMPLE_BITS  = 10,
  parameter int QUEUE_DEPTH  = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write port
  input  wire logic                          cfg_write_en,
  input  wire logic [clp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [clp_pkg::CFG_W-1:0]     cfg_data,
  // sample channel
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic                          opcode,
  input  wire logic [clp_pkg::CH_W-1:0]      channel,
  input  wire logic [clp_pkg::RAW_W-1:0]     raw_sample,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [clp_pkg::CH_W-1:0]           channel_out,
  output logic [clp_pkg::VALUE_W-1:0]        calibrated_value,
  output logic                               scan_done,
  output logic                               line_found,
  output logic [clp_pkg::POS_W-1:0]          line_position
);
  import clp_pkg::*;

  logic [CFG_W-1:0] channels_in_use;
  logic             white_line;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  entry_t           q_entry;
  entry_t           q_head;

  // Configuration registers; indexes outside the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CFG_W'(8);
      white_line      <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_CHANNELS_IN_USE: channels_in_use <= cfg_data;
        CFG_WHITE_LINE:      white_line      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Classify each accepted beat against the current channel count
  clp_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .sample_valid    (sample_valid),
    .sample_stall    (sample_stall),
    .opcode          (opcode),
    .channel         (channel),
    .raw_sample      (raw_sample),
    .channels_in_use (channels_in_use),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_entry         (q_entry)
  );

  // Decouple the front end from the multi-cycle back end
  clp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .entry_in (q_entry),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Calibrate, normalize, accumulate and report
  clp_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .white_line       (white_line),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .channel_out      (channel_out),
    .calibrated_value (calibrated_value),
    .scan_done        (scan_done),
    .line_found       (line_found),
    .line_position    (line_position)
  );

endmodule

`default_nettype wire

// File: design/clp_front.sv
// Front end: accepts sample beats and classifies them for the back end.
// Depends on clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_front #(
  parameter int MAX_CHANNELS = 16
) (
  input  wire logic                       sample_valid,
  output logic                            sample_stall,
  input  wire logic                       opcode,
  input  wire logic [clp_pkg::CH_W-1:0]   channel,
  input  wire logic [clp_pkg::RAW_W-1:0]  raw_sample,
  input  wire logic [clp_pkg::CFG_W-1:0]  channels_in_use,
  input  wire logic                       q_full,
  output logic                            q_push,
  output clp_pkg::entry_t                 q_entry
);
  import clp_pkg::*;

  localparam logic [CFG_W-1:0] MAX_CH = CFG_W'(MAX_CHANNELS);

  logic [CFG_W-1:0] used;
  logic [CFG_W-1:0] ch_wide;

  // Clamp the channel count to 1..MAX_CHANNELS
  always_comb begin
    if (channels_in_use == '0) begin
      used = CFG_W'(1);
    end else if (channels_in_use > MAX_CH) begin
      used = MAX_CH;
    end else begin
      used = channels_in_use;
    end
  end

  assign ch_wide = CFG_W'(channel);

  always_comb begin
    q_entry.is_meas  = (opcode == OP_MEASURE);
    q_entry.ch_known = (ch_wide < MAX_CH);
    q_entry.in_scan  = (ch_wide < used);
    q_entry.last     = (ch_wide == used - CFG_W'(1));
    q_entry.channel  = channel;
    q_entry.raw      = raw_sample;
  end

  // Hold off the sender while the queue is full
  assign sample_stall = q_full;
  assign q_push       = sample_valid && !q_full;

endmodule

`default_nettype wire

// File: design/clp_queue.sv
// Short queue of classified samples between front end and back end.
// Depends on clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire clp_pkg::entry_t entry_in,
  input  wire logic            pop,
  output clp_pkg::entry_t      head,
  output logic                 full,
  output logic                 empty
);
  import clp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  assert property (@(posedge clk) disable iff (rst) push && !pop |=> !empty)
    else $error("queue lost an entry");

endmodule

`default_nettype wire

// File: design/clp_div.sv
// Restoring serial divider, one quotient bit per cycle, shared by the
// normalize and position divides. Depends on clp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clp_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire clp_pkg::div_req_t             req,
  input  wire logic [clp_pkg::DIVIDEND_W-1:0] dividend,
  input  wire logic [clp_pkg::DIVISOR_W-1:0]  divisor,
  output logic                               done,
  output logic [clp_pkg::DIVIDEND_W-1:0]     quotient
);
  import clp_pkg::*;

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIV_CNT_W-1:0]  count;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign shifted  = {rem, quo[DIVIDEND_W-1]};
  assign fits     = (shifted >= {1'b0, dsr});
  assign diff     = shifted - {1'b0, dsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dsr <= divisor;
        if (req.short_mode) begin
          // high dividend bits are already below the divisor: skip them
          rem   <= dividend[DIVISOR_W+SHORT_Q-1:SHORT_Q];
          quo   <= {dividend[SHORT_Q-1:0], (DIVIDEND_W-SHORT_Q)'(0)};
          count <= DIV_CNT_W'(SHORT_Q);
        end else begin
          rem   <= '0;
          quo   <= dividend;
          count <= DIV_CNT_W'(DIVIDEND_W);
        end
      end else if (count != '0) begin
        rem   <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo   <= {quo[DIVIDEND_W-2:0], fits};
        count <= count - DIV_CNT_W'(1);
        done  <= (count == DIV_CNT_W'(1));
      end
    end
  end

endmodule

`default_nettype wire

// File: design/clp_back.sv
// Back end: calibration table, normalization, scan accumulators and the
// result register. Depends on clp_pkg and clp_div.
`timescale 1ns / 1ps
`default_nettype none

module clp_back #(
  parameter int MAX_CHANNELS = 16,
  parameter int SAMPLE_BITS  = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_empty,
  input  wire clp_pkg::entry_t             q_head,
  output logic                             q_pop,
  input  wire logic                        white_line,
  output logic                             result_valid,
  input  wire logic                        result_stall,
  output logic [clp_pkg::CH_W-1:0]         channel_out,
  output logic [clp_pkg::VALUE_W-1:0]      calibrated_value,
  output logic                             scan_done,
  output logic                             line_found,
  output logic [clp_pkg::POS_W-1:0]        line_position
);
  import clp_pkg::*;

  localparam int IDX_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NPROD_W  = SAMPLE_BITS + 10;  // 1000 * sample difference
  localparam int WPROD_W  = VALUE_W + CH_W;    // value * channel
  localparam logic [VALUE_W-1:0] FULL_V = VALUE_W'(FULL_SCALE);

  typedef enum logic [3:0] {
    S_IDLE, S_CAL, S_NORM, S_NDIV, S_PROD, S_SUM, S_END, S_PDIV, S_EMIT
  } state_t;

  state_t                   state;
  entry_t                   cur;
  logic [SAMPLE_BITS-1:0]   cal_min [MAX_CHANNELS];
  logic [SAMPLE_BITS-1:0]   cal_max [MAX_CHANNELS];
  logic [WSUM_W-1:0]        weighted_sum;
  logic [WTOT_W-1:0]        weight_total;
  logic [VALUE_W-1:0]       value;
  logic [WPROD_W-1:0]       wprod;
  logic                     end_flag;
  logic                     found_flag;
  logic [POS_W-1:0]         pos;

  logic [IDX_W-1:0]         idx;
  logic [MAX_SAMPLE_W-1:0]  raw_wide;
  logic [SAMPLE_BITS-1:0]   raw;
  logic [SAMPLE_BITS-1:0]   lo;
  logic [SAMPLE_BITS-1:0]   hi;
  logic [SAMPLE_BITS-1:0]   num_diff;
  logic [SAMPLE_BITS-1:0]   den_diff;
  logic                     need_div;
  logic [VALUE_W-1:0]       sat_v;
  logic [NPROD_W-1:0]       nprod;
  logic                     emit_fire;

  div_req_t                 div_req;
  logic                     div_done;
  logic [DIVIDEND_W-1:0]    div_dividend;
  logic [DIVISOR_W-1:0]     div_divisor;
  logic [DIVIDEND_W-1:0]    div_quo;

  assign idx      = cur.channel[IDX_W-1:0];
  assign raw_wide = MAX_SAMPLE_W'(cur.raw);
  assign raw      = raw_wide[SAMPLE_BITS-1:0];
  assign lo       = cal_min[idx];
  assign hi       = cal_max[idx];

  // Split the signed normalize into saturated cases and one unsigned divide
  always_comb begin
    need_div = 1'b0;
    sat_v    = '0;
    num_diff = '0;
    if (hi > lo) begin
      den_diff = hi - lo;
      if (raw <= lo) begin
        sat_v = '0;
      end else if (raw >= hi) begin
        sat_v = FULL_V;
      end else begin
        need_div = 1'b1;
        num_diff = raw - lo;
      end
    end else begin
      den_diff = lo - hi;
      if (raw >= lo) begin
        sat_v = '0;
      end else if (raw <= hi) begin
        sat_v = FULL_V;
      end else begin
        need_div = 1'b1;
        num_diff = lo - raw;
      end
    end
  end

  assign nprod = NPROD_W'(num_diff) * NPROD_W'(FULL_SCALE);

  always_comb begin
    div_req.start      = 1'b0;
    div_req.short_mode = 1'b1;
    div_dividend       = DIVIDEND_W'(nprod);
    div_divisor        = DIVISOR_W'(den_diff);
    if (state == S_NORM) begin
      div_req.start = cur.ch_known && (hi != lo) && need_div;
    end else if (state == S_END) begin
      div_req.start      = cur.in_scan && cur.last && (weight_total != '0);
      div_req.short_mode = 1'b0;
      div_dividend       = weighted_sum;
      div_divisor        = weight_total;
    end
  end

  clp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign emit_fire = (state == S_EMIT) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      weighted_sum <= '0;
      weight_total <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        cal_min[i] <= '1;
        cal_max[i] <= '0;
      end
    end else begin
      if (emit_fire) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur   <= q_head;
            state <= q_head.is_meas ? S_NORM : S_CAL;
          end
        end
        S_CAL: begin
          if (cur.ch_known) begin
            if (raw < lo) begin
              cal_min[idx] <= raw;
            end
            if (raw > hi) begin
              cal_max[idx] <= raw;
            end
          end
          state <= S_IDLE;
        end
        S_NORM: begin
          if (!cur.ch_known || (hi == lo)) begin
            value <= '0;
            state <= S_PROD;
          end else if (need_div) begin
            state <= S_NDIV;
          end else begin
            value <= white_line ? FULL_V - sat_v : sat_v;
            state <= S_PROD;
          end
        end
        S_NDIV: begin
          if (div_done) begin
            value <= white_line ? FULL_V - div_quo[VALUE_W-1:0] : div_quo[VALUE_W-1:0];
            state <= S_PROD;
          end
        end
        S_PROD: begin
          wprod <= WPROD_W'(value) * WPROD_W'(cur.channel);
          state <= S_SUM;
        end
        S_SUM: begin
          if (cur.in_scan && (value > VALUE_W'(THRESHOLD))) begin
            weighted_sum <= weighted_sum + WSUM_W'(WSUM_W'(wprod) * WSUM_W'(FULL_SCALE));
            weight_total <= weight_total + WTOT_W'(value);
          end
          state <= S_END;
        end
        S_END: begin
          end_flag   <= cur.in_scan && cur.last;
          found_flag <= 1'b0;
          pos        <= '0;
          if (cur.in_scan && cur.last) begin
            // divider has latched the sums; clear for the next scan
            weighted_sum <= '0;
            weight_total <= '0;
          end
          if (cur.in_scan && cur.last && (weight_total != '0)) begin
            state <= S_PDIV;
          end else begin
            state <= S_EMIT;
          end
        end
        S_PDIV: begin
          if (div_done) begin
            found_flag <= 1'b1;
            pos        <= div_quo[POS_W-1:0];
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            channel_out      <= cur.channel;
            calibrated_value <= value;
            scan_done        <= end_flag;
            line_found       <= found_flag;
            line_position    <= pos;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && !scan_done |-> !line_found && (line_position == '0))
    else $error("line report outside a scan end");
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> calibrated_value <= FULL_V)
    else $error("calibrated value above full scale");
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_NDIV) || (state == S_PDIV))
    else $error("divider finished with nobody waiting");

endmodule

`default_nettype wire
